// ===== hw/rtl/nfha_pkg.sv =====
// Shared constants, types and state codes of the next-fit heap allocator.
package nfha_pkg;
  localparam int HEAP_WORDS = 4096;
  localparam int WORD_BYTES = 8;
  localparam int IDX_W = $clog2(HEAP_WORDS);
  localparam int CFG_W = IDX_W + 1;
  localparam int NW_W = IDX_W + 2;
  localparam int BUDGET = 4 * HEAP_WORDS + 8;
  localparam int BUD_W = $clog2(BUDGET + 1);

  localparam logic [1:0] OP_INIT = 2'd0;
  localparam logic [1:0] OP_ALLOC = 2'd1;
  localparam logic [1:0] OP_FREE = 2'd2;

  localparam logic [1:0] ST_OK = 2'd0;
  localparam logic [1:0] ST_BAD_PARAM = 2'd1;
  localparam logic [1:0] ST_NO_SPACE = 2'd2;

  typedef struct packed {
    logic used;
    logic [IDX_W-1:0] nxt;
  } link_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_INIT1,
    S_CUR,
    S_MRG,
    S_CHK,
    S_COMMIT,
    S_COMMIT2,
    S_FREE
  } state_t;
endpackage

// ===== hw/rtl/nfha_ram.sv =====
// Link word memory with one write port and one registered read port.
module nfha_ram (
  input  logic clk,
  input  logic we,
  input  logic [nfha_pkg::IDX_W-1:0] waddr,
  input  nfha_pkg::link_t wdata,
  input  logic [nfha_pkg::IDX_W-1:0] raddr,
  output nfha_pkg::link_t rdata
);
  import nfha_pkg::*;

  link_t mem [HEAP_WORDS];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // A read of the word being written returns the new value.
  always_ff @(posedge clk) begin
    if (we && waddr == raddr) begin
      rdata <= wdata;
    end else begin
      rdata <= mem[raddr];
    end
  end
endmodule

// ===== hw/rtl/next_fit_heap_allocator.sv =====
// Next-fit heap allocator: sequencer around the link memory and one compare unit.
// One link read a cycle. Init writes the free block, then the sentinel in S_INIT1; free reads
// the header, then rewrites it in S_FREE. Allocate: S_CUR, S_CHK per used block, S_CUR, S_MRG,
// S_CHK per free one, an S_MRG per merged neighbor, S_COMMIT, S_COMMIT2. All raise done on
// going idle; a bad request stays idle. A start can be taken at the edge ending done.
// Synchronous reset clears the sequencer, the rover and done, and sets heap_words to its default.
module next_fit_heap_allocator (
  input  logic clk,
  input  logic rst,
  input  logic start,
  output logic busy,
  input  logic [1:0] opcode,
  input  logic signed [15:0] size_bytes,
  input  logic [nfha_pkg::IDX_W-1:0] request_index,
  input  logic cfg_valid,
  output logic cfg_ready,
  input  logic [nfha_pkg::CFG_W-1:0] cfg_data,
  output logic done,
  output logic [1:0] status,
  output logic [nfha_pkg::IDX_W-1:0] granted_index
);
  import nfha_pkg::*;

  state_t state, state_next;
  logic [IDX_W-1:0] cur, cur_next;
  logic [IDX_W-1:0] nxt, nxt_next;
  logic [IDX_W-1:0] cw_next, cw_next_next;
  logic [IDX_W-1:0] nw_next, nw_next_next;
  logic [IDX_W-1:0] rover, rover_next;
  logic [BUD_W-1:0] budget, budget_next;
  logic wraps, wraps_next;
  logic [NW_W-1:0] nwords, nwords_next;
  logic [CFG_W-1:0] heap_words;
  logic done_next;
  logic [1:0] status_next;
  logic [IDX_W-1:0] granted_next;

  logic ram_we;
  logic [IDX_W-1:0] ram_waddr, ram_raddr;
  link_t ram_wdata, ram_rdata;

  logic [IDX_W-1:0] last_word;
  logic [NW_W-1:0] size_words;
  logic [NW_W-1:0] cur_end;
  logic [IDX_W-1:0] req_hdr;

  nfha_ram u_ram (
    .clk  (clk),
    .we   (ram_we),
    .waddr(ram_waddr),
    .wdata(ram_wdata),
    .raddr(ram_raddr),
    .rdata(ram_rdata)
  );

  // Configuration register always writable; the user changes it only while idle, unchecked.
  assign cfg_ready = 1'b1;
  assign busy = (state != S_IDLE);

  // Heap size saturated into the range two to HEAP_WORDS, then the last word index.
  always_comb begin
    if (heap_words < CFG_W'(2)) begin
      last_word = IDX_W'(1);
    end else if (heap_words > CFG_W'(HEAP_WORDS)) begin
      last_word = IDX_W'(HEAP_WORDS - 1);
    end else begin
      last_word = IDX_W'(heap_words - CFG_W'(1));
    end
  end

  // Header word plus payload words rounded up.
  assign size_words = NW_W'((17'(size_bytes[14:0]) + 17'(WORD_BYTES - 1)) / WORD_BYTES)
                      + NW_W'(1);
  assign cur_end = NW_W'(cur) + nwords;
  assign req_hdr = request_index - IDX_W'(1);

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      rover <= '0;
      heap_words <= CFG_W'(HEAP_WORDS);
      done <= 1'b0;
    end else begin
      state <= state_next;
      rover <= rover_next;
      done <= done_next;
      if (cfg_valid && cfg_ready) begin
        heap_words <= cfg_data;
      end
    end
  end

  always_ff @(posedge clk) begin
    cur <= cur_next;
    nxt <= nxt_next;
    cw_next <= cw_next_next;
    nw_next <= nw_next_next;
    budget <= budget_next;
    wraps <= wraps_next;
    nwords <= nwords_next;
    status <= status_next;
    granted_index <= granted_next;
  end

  always_comb begin
    state_next = state;
    cur_next = cur;
    nxt_next = nxt;
    cw_next_next = cw_next;
    nw_next_next = nw_next;
    rover_next = rover;
    budget_next = budget;
    wraps_next = wraps;
    nwords_next = nwords;
    done_next = 1'b0;
    status_next = status;
    granted_next = granted_index;
    ram_we = 1'b0;
    ram_waddr = cur;
    ram_wdata = '{used: 1'b0, nxt: '0};
    ram_raddr = cur;

    case (state)
      S_IDLE: begin
        if (start) begin
          status_next = ST_OK;
          granted_next = '0;
          case (opcode)
            OP_INIT: begin
              // Free block at word zero up to the sentinel.
              ram_we = 1'b1;
              ram_waddr = '0;
              ram_wdata = '{used: 1'b0, nxt: last_word};
              rover_next = '0;
              state_next = S_INIT1;
            end
            OP_ALLOC: begin
              if (size_bytes[15]) begin
                status_next = ST_BAD_PARAM;
                done_next = 1'b1;
              end else begin
                cur_next = rover;
                ram_raddr = rover;
                budget_next = BUD_W'(BUDGET);
                wraps_next = 1'b0;
                nwords_next = size_words;
                state_next = S_CUR;
              end
            end
            OP_FREE: begin
              if (request_index == '0) begin
                status_next = ST_BAD_PARAM;
                done_next = 1'b1;
              end else begin
                cur_next = req_hdr;
                rover_next = req_hdr;
                ram_raddr = req_hdr;
                state_next = S_FREE;
              end
            end
            default: begin
              status_next = ST_BAD_PARAM;
              done_next = 1'b1;
            end
          endcase
        end
      end
      S_INIT1: begin
        // Used sentinel in the last word links back to word zero.
        ram_we = 1'b1;
        ram_waddr = last_word;
        ram_wdata = '{used: 1'b1, nxt: '0};
        done_next = 1'b1;
        state_next = S_IDLE;
      end
      S_FREE: begin
        ram_we = 1'b1;
        ram_waddr = cur;
        ram_wdata = '{used: 1'b0, nxt: ram_rdata.nxt};
        done_next = 1'b1;
        state_next = S_IDLE;
      end
      S_CUR: begin
        if (!ram_rdata.used) begin
          cw_next_next = ram_rdata.nxt;
          nxt_next = ram_rdata.nxt;
          ram_raddr = ram_rdata.nxt;
          state_next = S_MRG;
        end else begin
          nxt_next = cur;
          nw_next_next = ram_rdata.nxt;
          state_next = S_CHK;
        end
      end
      S_MRG: begin
        if (!ram_rdata.used) begin
          // Absorb the free neighbor into the current block.
          if (budget == '0) begin
            status_next = ST_NO_SPACE;
            done_next = 1'b1;
            state_next = S_IDLE;
          end else begin
            budget_next = budget - BUD_W'(1);
            cw_next_next = ram_rdata.nxt;
            nxt_next = ram_rdata.nxt;
            ram_we = 1'b1;
            ram_waddr = cur;
            ram_wdata = '{used: 1'b0, nxt: ram_rdata.nxt};
            ram_raddr = ram_rdata.nxt;
          end
        end else begin
          nw_next_next = ram_rdata.nxt;
          if (cur < rover && rover < cw_next) begin
            rover_next = cur;
          end
          state_next = S_CHK;
        end
      end
      S_CHK: begin
        if (NW_W'(nxt) >= cur_end) begin
          state_next = S_COMMIT;
        end else if (nxt > nw_next && wraps) begin
          status_next = ST_NO_SPACE;
          done_next = 1'b1;
          state_next = S_IDLE;
        end else if (budget == '0) begin
          status_next = ST_NO_SPACE;
          done_next = 1'b1;
          state_next = S_IDLE;
        end else begin
          if (nxt > nw_next) begin
            wraps_next = 1'b1;
          end
          budget_next = budget - BUD_W'(1);
          cur_next = nw_next;
          ram_raddr = nw_next;
          state_next = S_CUR;
        end
      end
      S_COMMIT: begin
        // Split off the tail as a new free block when the fit is not exact.
        rover_next = cur_end[IDX_W-1:0];
        if (NW_W'(nxt) > cur_end) begin
          ram_we = 1'b1;
          ram_waddr = cur_end[IDX_W-1:0];
          ram_wdata = '{used: 1'b0, nxt: cw_next};
        end
        state_next = S_COMMIT2;
      end
      S_COMMIT2: begin
        ram_we = 1'b1;
        ram_waddr = cur;
        ram_wdata = '{used: 1'b1, nxt: rover};
        status_next = ST_OK;
        granted_next = cur + IDX_W'(1);
        done_next = 1'b1;
        state_next = S_IDLE;
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end
endmodule

// ===== tb/sv/tb_top.sv =====
// Self-checking testbench for the next-fit heap allocator with its own heap-link predictor.
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;
  import nfha_pkg::*;

  // Result struct shared by the predictor and the checker.
  typedef struct packed {
    logic [1:0] status;
    logic [IDX_W-1:0] granted;
  } heap_reply_t;

  // Scoreboard: keeps a shadow copy of the heap links, the rover and the heap size.
  // Each accepted request is applied to the shadow, and the predicted reply is queued.
  class heap_scoreboard;
    logic [IDX_W-1:0] link_next [HEAP_WORDS];
    bit link_used [HEAP_WORDS];
    int unsigned rover_pos;
    int unsigned cfg_words;
    heap_reply_t pending_replies[$];
    int unsigned mismatch_count;
    int unsigned reply_count;

    function void clear_state();
      for (int i = 0; i < HEAP_WORDS; i++) begin
        link_next[i] = '0;
        link_used[i] = 1'b0;
      end
      rover_pos = 0;
      cfg_words = HEAP_WORDS;
    endfunction

    function void set_heap_words(int unsigned value);
      cfg_words = value & 32'h1FFF;
    endfunction

    // Next-fit search with lazy merging of free neighbors; returns the status code.
    function logic [1:0] find_block(int unsigned nwords, output int unsigned payload);
      int unsigned budget;
      int unsigned cur;
      int unsigned nxt;
      int unsigned wraps;
      budget = 4 * HEAP_WORDS + 8;
      cur = rover_pos;
      wraps = 0;
      payload = 0;
      forever begin
        if (!link_used[cur]) begin
          nxt = link_next[cur];
          while (!link_used[nxt]) begin
            if (budget == 0) return ST_NO_SPACE;
            budget--;
            link_next[cur] = link_next[nxt];
            nxt = link_next[cur];
          end
          if (cur < rover_pos && rover_pos < link_next[cur]) rover_pos = cur;
        end else begin
          nxt = cur;
        end
        if (nxt >= cur + nwords) break;
        if (nxt > link_next[nxt]) begin
          wraps++;
          if (wraps > 1) return ST_NO_SPACE;
        end
        if (budget == 0) return ST_NO_SPACE;
        budget--;
        cur = link_next[nxt];
      end
      rover_pos = cur + nwords;
      // Split when the found block is larger than needed.
      if (nxt > rover_pos) begin
        link_next[rover_pos] = link_next[cur];
        link_used[rover_pos] = 1'b0;
      end
      link_next[cur] = IDX_W'(rover_pos);
      link_used[cur] = 1'b1;
      payload = cur + 1;
      return ST_OK;
    endfunction

    function void note_request(logic [1:0] op, logic [15:0] size, logic [IDX_W-1:0] req);
      heap_reply_t reply;
      int unsigned n;
      int unsigned payload;
      reply = '0;
      if (op == OP_INIT) begin
        n = cfg_words;
        if (n < 2) n = 2;
        if (n > HEAP_WORDS) n = HEAP_WORDS;
        link_next[0] = IDX_W'(n - 1);
        link_used[0] = 1'b0;
        link_next[n - 1] = '0;
        link_used[n - 1] = 1'b1;
        rover_pos = 0;
      end else if (op == OP_ALLOC) begin
        if (size[15]) begin
          reply.status = ST_BAD_PARAM;
        end else begin
          n = 1 + (int'(size) + WORD_BYTES - 1) / WORD_BYTES;
          reply.status = find_block(n, payload);
          if (reply.status == ST_OK) reply.granted = payload[IDX_W-1:0];
        end
      end else if (op == OP_FREE) begin
        if (req == 0) begin
          reply.status = ST_BAD_PARAM;
        end else begin
          rover_pos = req - 1;
          link_used[rover_pos] = 1'b0;
        end
      end else begin
        reply.status = ST_BAD_PARAM;
      end
      pending_replies.push_back(reply);
    endfunction

    task check_reply(logic [1:0] st, logic [IDX_W-1:0] granted);
      heap_reply_t want;
      reply_count++;
      if (pending_replies.size() == 0) begin
        report_mismatch("reply with no request outstanding", 0, st);
        return;
      end
      want = pending_replies.pop_front();
      if (st !== want.status) report_mismatch("status", want.status, st);
      if (granted !== want.granted) report_mismatch("granted_index", want.granted, granted);
    endtask

    task report_mismatch(string what, int unsigned want, int unsigned got);
      mismatch_count++;
      $display("MISMATCH %s: expected %0d, got %0d", what, want, got);
    endtask
  endclass

  logic clk;
  logic rst;
  logic start;
  logic busy;
  logic [1:0] opcode;
  logic signed [15:0] size_bytes;
  logic [IDX_W-1:0] request_index;
  logic cfg_valid;
  logic cfg_ready;
  logic [CFG_W-1:0] cfg_data;
  logic done;
  logic [1:0] status;
  logic [IDX_W-1:0] granted_index;

  heap_scoreboard sb;
  int unsigned cycle_count;
  int unsigned request_count;
  int unsigned no_space_count;
  // Payload indexes handed out and not yet released; freeing them keeps the heap healthy.
  int unsigned live_blocks[$];

  next_fit_heap_allocator DUT (
    .clk(clk), .rst(rst), .start(start), .busy(busy),
    .opcode(opcode), .size_bytes(size_bytes), .request_index(request_index),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_data(cfg_data),
    .done(done), .status(status), .granted_index(granted_index)
  );

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  // Results cannot be held off, so every strobe is checked at the edge that ends it.
  // Accepted grants are remembered so later frees can target real blocks.
  always @(posedge clk) begin
    if (!rst && done) begin
      if (sb.pending_replies.size() > 0 && status == ST_OK && granted_index != 0)
        live_blocks.push_back(granted_index);
      if (status == ST_NO_SPACE) no_space_count++;
      sb.check_reply(status, granted_index);
    end
  end

  // Watchdog: allocations can walk thousands of links, so the limit is generous.
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > 250_000_000) begin
      $display("next_fit_heap_allocator verification failed");
      $finish;
    end
  end

  // Waits out a random number of cycles: mostly none or a few, now and then a long pause.
  // The request strobe is dropped only when a real gap follows.
  task automatic idle_gap();
    int unsigned n;
    case ($urandom_range(0, 9))
      0, 1, 2, 3: n = 0;
      4, 5, 6, 7, 8: n = $urandom_range(1, 4);
      default: n = $urandom_range(10, 60);
    endcase
    if (n != 0) start <= 1'b0;
    repeat (n) @(posedge clk);
  endtask

  // Presents one request and holds it until a transfer happens at an edge with busy low.
  task automatic send_request(logic [1:0] op, logic [15:0] size, logic [IDX_W-1:0] req);
    start <= 1'b1;
    opcode <= op;
    size_bytes <= size;
    request_index <= req;
    do @(posedge clk); while (busy);
    sb.note_request(op, size, req);
    request_count++;
    if (op == OP_INIT) begin
      live_blocks.delete();
    end
    idle_gap();
  endtask

  // Lets every outstanding reply arrive, then a few extra cycles for the block to settle.
  task automatic drain_replies();
    start <= 1'b0;
    while (sb.pending_replies.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
  endtask

  // Writes heap_words while the block is idle.
  task automatic write_heap_words(int unsigned value);
    drain_replies();
    cfg_valid <= 1'b1;
    cfg_data <= value[CFG_W-1:0];
    do @(posedge clk); while (!cfg_ready);
    sb.set_heap_words(value);
    cfg_valid <= 1'b0;
    @(posedge clk);
  endtask

  // Free of a live block when one exists, most of the time, else of the first block, whose header init writes.
  task automatic free_some_block();
    int unsigned pick;
    int unsigned idx;
    if (live_blocks.size() > 0 && $urandom_range(0, 9) != 0) begin
      pick = $urandom_range(0, live_blocks.size() - 1);
      idx = live_blocks[pick];
      live_blocks.delete(pick);
    end else begin
      idx = 1;
    end
    send_request(OP_FREE, 16'($urandom), idx[IDX_W-1:0]);
  endtask

  // Mostly small sizes, some medium, a few very large ones that usually fail and negative ones that must fail.
  function automatic logic [15:0] pick_size();
    case ($urandom_range(0, 19))
      0: return 16'(16'h7FFF - $urandom_range(0, 255));
      1: return 16'(16'h8000 | $urandom);
      2, 3: return 16'($urandom_range(0, 2000));
      default: return 16'($urandom_range(0, 120));
    endcase
  endfunction

  // Random phase: a working heap of the given size with alloc-heavy traffic and noise.
  task automatic random_phase(int unsigned words, int unsigned items);
    int unsigned r;
    write_heap_words(words);
    send_request(OP_INIT, 16'($urandom), IDX_W'($urandom));
    for (int i = 0; i < items; i++) begin
      r = $urandom_range(0, 99);
      if (r < 55) send_request(OP_ALLOC, pick_size(), IDX_W'($urandom));
      else if (r < 93) free_some_block();
      else if (r < 95) send_request(OP_FREE, 16'($urandom), '0);
      else if (r < 97) send_request(2'd3, 16'($urandom), IDX_W'($urandom));
      else send_request(OP_INIT, 16'($urandom), IDX_W'($urandom));
    end
  endtask

  initial begin
    sb = new();
    sb.clear_state();
    cycle_count = 0;
    request_count = 0;
    no_space_count = 0;
    rst = 1'b1;
    start = 1'b0;
    opcode = OP_INIT;
    size_bytes = '0;
    request_index = '0;
    cfg_valid = 1'b0;
    cfg_data = '0;
    repeat (11) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Directed part: the reset heap size, every opcode, and the bad-parameter cases.
    send_request(OP_INIT, 16'h0000, '0);
    send_request(OP_ALLOC, 16'h0000, '0);
    send_request(OP_ALLOC, 16'h0001, '0);
    send_request(OP_ALLOC, 16'h0008, 12'hFFF);
    send_request(OP_ALLOC, 16'h0009, '0);
    send_request(OP_ALLOC, 16'h8000, '0);
    send_request(OP_ALLOC, 16'hFFFF, '0);
    send_request(OP_ALLOC, 16'h7FFF, '0);
    send_request(OP_FREE, 16'hFFFF, '0);
    send_request(2'd3, 16'hFFFF, 12'hFFF);
    send_request(OP_FREE, '0, 12'd2);
    // Freeing a block twice is allowed without a check.
    send_request(OP_FREE, '0, 12'd2);
    send_request(OP_ALLOC, 16'd7000, '0);
    send_request(OP_ALLOC, 16'd32000, '0);
    send_request(OP_ALLOC, 16'd100, '0);

    // Heap size clamped from below and above, then the smallest usable heap.
    write_heap_words(0);
    send_request(OP_INIT, '0, '0);
    send_request(OP_ALLOC, 16'd0, '0);
    write_heap_words(13'h1FFF);
    send_request(OP_INIT, '0, '0);
    send_request(OP_ALLOC, 16'd32760, '0);
    write_heap_words(2);
    send_request(OP_INIT, '0, '0);
    send_request(OP_ALLOC, 16'd0, '0);
    send_request(OP_ALLOC, 16'd0, '0);
    send_request(OP_FREE, '0, 12'd1);

    // Random phases over several heap sizes; the drain inside each config write is
    // also the point where the sender waits for every reply.
    random_phase(64, 250);
    random_phase($urandom_range(3, 300), 250);
    random_phase(4096, 300);
    random_phase(16, 150);
    random_phase(13'h1000 + $urandom_range(0, 4095), 150);

    drain_replies();
    $display("Covered %0d requests over heap sizes from 2 to 4096 words; %0d ended with no space.",
             request_count, no_space_count);
    if (sb.mismatch_count == 0 && sb.pending_replies.size() == 0) begin
      $display("next_fit_heap_allocator verification clean");
    end else begin
      $display("next_fit_heap_allocator verification failed");
    end
    $finish;
  end
endmodule
